/* rtl/skst_pkg.sv */
// Package: constants and types for the sorted key state table.
package skst_pkg;

   localparam int ENTRIES   = 256;
   localparam int NUM_TBL   = 3;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int ADDR_W    = $clog2(NUM_TBL * ENTRIES);
   localparam int DEPTH     = NUM_TBL * ENTRIES;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADSEL = 2'd2,
      ST_RSVD   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  table_sel;
      logic [15:0] key_low;
      logic [15:0] key_high;
      logic [15:0] new_state;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] state_out;
      logic [8:0]  position;
      logic [1:0]  status;
   } rsp_type;

endpackage

/* rtl/skst_if.sv */
// Interfaces: valid/ready channels for requests and results.
interface skst_req_if;
   import skst_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface skst_rsp_if;
   import skst_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/sorted_key_state_table_top.sv */
// Top level: sorted key/state tables with binary search and shifting insert.
// Clear, bad table select and unused commands go straight from accept to the
// response; a lookup runs a binary search with one memory read per probe and
// a final compare; an insert on a miss reads then writes each shifted entry
// and then stores the new pair.
// One request at a time: a new request is taken only after the response is taken.
// Reset: synchronous, clears fill counts; the stores are not cleared.
module sorted_key_state_table_top (
   input logic      clock,
   input logic      reset,
   skst_req_if.sink   req,
   skst_rsp_if.source rsp
);
   import skst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PROBE, S_EVAL, S_FINAL, S_SHRD, S_SHWR, S_PUT, S_RSP
   } fsm_type;

   // Key and state memories
   logic [31:0] key_mem [DEPTH];
   logic [15:0] val_mem [DEPTH];

   fsm_type        st_ff;
   req_type        r_ff;
   rsp_type        o_ff;
   logic [CNT_W-1:0] fill_ff [NUM_TBL];
   logic [CNT_W-1:0] lo_ff, hi_ff, n_ff, i_ff;
   logic [ADDR_W-1:0] base_ff;

   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic        rd_en, wr_en;
   logic [31:0] wr_key, rd_key;
   logic [15:0] wr_val, rd_val;

   logic [31:0] key;
   logic [CNT_W-1:0] mid, cnt_sel;
   assign key = {r_ff.key_high, r_ff.key_low};
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign cnt_sel = fill_ff[req.data.table_sel];

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = (st_ff == S_RSP);
   assign rsp.data  = o_ff;

   // Memory ports: one read, one write per cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key <= key_mem[rd_addr];
         rd_val <= val_mem[rd_addr];
      end
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
   end

   // Drive memory addresses from the sequencer state
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = base_ff + ADDR_W'(mid);
      wr_en   = 1'b0;
      wr_addr = base_ff + ADDR_W'(i_ff);
      wr_key  = rd_key;
      wr_val  = rd_val;
      case (st_ff)
         S_PROBE: rd_en = (lo_ff < hi_ff) || (lo_ff < n_ff);
         S_SHRD: begin
            rd_en   = 1'b1;
            rd_addr = base_ff + ADDR_W'(i_ff - 1'b1);
         end
         S_SHWR: wr_en = 1'b1;
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = base_ff + ADDR_W'(lo_ff);
            wr_key  = key;
            wr_val  = r_ff.new_state;
         end
         S_FINAL: begin
            wr_en   = (r_ff.cmd == CMD_INSERT) && (lo_ff < n_ff) && (rd_key == key);
            wr_addr = base_ff + ADDR_W'(lo_ff);
            wr_key  = key;
            wr_val  = r_ff.new_state;
         end
         default: ;
      endcase
      if (st_ff == S_PROBE && !(lo_ff < hi_ff)) rd_addr = base_ff + ADDR_W'(lo_ff);
   end

   // Sequencer: search, shift, store, respond
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         for (int t = 0; t < NUM_TBL; t++) fill_ff[t] <= '0;
      end else begin
         case (st_ff)
            S_IDLE: if (req.valid) begin
               r_ff    <= req.data;
               o_ff    <= '0;
               lo_ff   <= '0;
               st_ff   <= S_RSP;
               if (req.data.cmd == CMD_CLEAR) begin
                  for (int t = 0; t < NUM_TBL; t++) fill_ff[t] <= '0;
               end else if (req.data.cmd == CMD_LOOKUP || req.data.cmd == CMD_INSERT) begin
                  if (req.data.table_sel == 2'd3) begin
                     o_ff.status <= ST_BADSEL;
                  end else begin
                     hi_ff   <= cnt_sel;
                     n_ff    <= cnt_sel;
                     base_ff <= ADDR_W'(req.data.table_sel) * ADDR_W'(ENTRIES);
                     st_ff   <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               if (lo_ff < hi_ff) st_ff <= S_EVAL;
               else if (lo_ff < n_ff) st_ff <= S_FINAL;
               else st_ff <= S_FINAL;
            end
            S_EVAL: begin
               if (rd_key < key) lo_ff <= mid + 1'b1;
               else hi_ff <= mid;
               st_ff <= S_PROBE;
            end
            S_FINAL: begin
               o_ff.position <= 9'(lo_ff);
               if ((lo_ff < n_ff) && (rd_key == key)) begin
                  o_ff.hit <= 1'b1;
                  if (r_ff.cmd == CMD_LOOKUP) o_ff.state_out <= rd_val;
                  st_ff <= S_RSP;
               end else if (r_ff.cmd == CMD_LOOKUP) begin
                  st_ff <= S_RSP;
               end else if (n_ff >= CNT_W'(ENTRIES)) begin
                  o_ff.status <= ST_FULL;
                  st_ff <= S_RSP;
               end else begin
                  i_ff  <= n_ff;
                  st_ff <= (n_ff > lo_ff) ? S_SHRD : S_PUT;
               end
            end
            S_SHRD: st_ff <= S_SHWR;
            S_SHWR: begin
               i_ff  <= i_ff - 1'b1;
               st_ff <= ((i_ff - 1'b1) > lo_ff) ? S_SHRD : S_PUT;
            end
            S_PUT: begin
               fill_ff[r_ff.table_sel] <= n_ff + 1'b1;
               st_ff <= S_RSP;
            end
            S_RSP: if (rsp.ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* rtl/skst_checker.sv */
// Checker: port-level properties of the sorted key state table.
module skst_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input skst_pkg::rsp_type rsp_data
);
   import skst_pkg::*;

   // A result never coexists with an open request slot
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   // A result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");

   // Status is never the reserved code
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != ST_RSVD) else $error("bad status");

   // A hit reports ok status
   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.status == ST_OK)
      else $error("hit with error status");

   // After a result is taken the block is ready again
   a_ret: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready) else $error("not ready after result");

endmodule

bind sorted_key_state_table_top skst_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

/* bench/tb_top.sv */
// Testbench for the sorted key state table: directed table plus random requests.
`timescale 1ns / 100ps

module tb_top;
   import skst_pkg::*;

   localparam int CYCLE_LIMIT = 1_200_000;
   localparam int DRAIN_WAIT  = 2 * ENTRIES + 40;

   logic clock;
   logic reset;
   skst_req_if req ();
   skst_rsp_if rsp ();

   sorted_key_state_table_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // Shadow copy of the three tables
   logic [31:0] shadow_key [NUM_TBL][ENTRIES];
   logic [15:0] shadow_val [NUM_TBL][ENTRIES];
   int          shadow_fill [NUM_TBL];

   rsp_type     expected_rsp_q [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic [31:0] key_pool [48];

   typedef struct {
      req_type r;
      bit      known;
      rsp_type e;
   } stim_row;

   // Clock generation
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Compute the response of one request and update the shadow tables
   function automatic rsp_type table_access(req_type r);
      rsp_type     o;
      logic [31:0] key;
      int          t, n, pos;
      bit          found;
      o = '0;
      key = {r.key_high, r.key_low};
      t = r.table_sel;
      if (r.cmd == CMD_CLEAR) begin
         for (int i = 0; i < NUM_TBL; i++) shadow_fill[i] = 0;
         return o;
      end
      if (r.cmd != CMD_LOOKUP && r.cmd != CMD_INSERT) return o;
      if (t >= NUM_TBL) begin
         o.status = ST_BADSEL;
         return o;
      end
      n = shadow_fill[t];
      pos = 0;
      while (pos < n && shadow_key[t][pos] < key) pos++;
      found = (pos < n) && (shadow_key[t][pos] == key);
      o.position = pos[8:0];
      o.status = ST_OK;
      if (r.cmd == CMD_LOOKUP) begin
         o.hit = found;
         if (found) o.state_out = shadow_val[t][pos];
         return o;
      end
      if (found) begin
         shadow_val[t][pos] = r.new_state;
         o.hit = 1'b1;
         return o;
      end
      if (n >= ENTRIES) begin
         o.status = ST_FULL;
         return o;
      end
      for (int i = n; i > pos; i--) begin
         shadow_key[t][i] = shadow_key[t][i-1];
         shadow_val[t][i] = shadow_val[t][i-1];
      end
      shadow_key[t][pos] = key;
      shadow_val[t][pos] = r.new_state;
      shadow_fill[t] = n + 1;
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // Drive one request, then hold until it is accepted
   task automatic send_request(req_type r, bit known, rsp_type e);
      rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= r;
      do @(posedge clock); while (!req.ready);
      p = table_access(r);
      expected_rsp_q.push_back(known ? e : p);
   endtask

   function automatic req_type make_req(logic [1:0] c, logic [1:0] s, logic [31:0] k,
                                        logic [15:0] v);
      req_type r;
      r.cmd = c;
      r.table_sel = s;
      r.key_high = k[31:16];
      r.key_low = k[15:0];
      r.new_state = v;
      return r;
   endfunction

   function automatic logic [31:0] pick_key();
      if ($urandom_range(3) != 0) return key_pool[$urandom_range(47)];
      return $urandom;
   endfunction

   task automatic send_random(int n, bit allow_clear);
      logic [1:0] c, s;
      int         roll;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 48) c = CMD_INSERT;
         else if (roll < 92) c = CMD_LOOKUP;
         else if (roll < 96 && allow_clear) c = CMD_CLEAR;
         else c = CMD_NONE;
         s = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(NUM_TBL - 1));
         send_request(make_req(c, s, pick_key(), 16'($urandom)), 1'b0, '0);
      end
   endtask

   // Receiver: random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("unexpected response at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp.data.hit !== want.hit)
               report_mismatch("hit", rsp.data.hit, want.hit);
            if (rsp.data.state_out !== want.state_out)
               report_mismatch("state_out", rsp.data.state_out, want.state_out);
            if (rsp.data.position !== want.position)
               report_mismatch("position", rsp.data.position, want.position);
            if (rsp.data.status !== want.status)
               report_mismatch("status", rsp.data.status, want.status);
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      stim_row rows [$];
      stim_row w;
      rsp_type z;
      z = '0;
      send_idle_pct = 7;
      recv_idle_pct = 79;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      for (int t = 0; t < NUM_TBL; t++) shadow_fill[t] = 0;
      for (int i = 0; i < 48; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h0000_FFFF;
      key_pool[4] = 32'hFFFF_0000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      w.known = 1; w.e = z;
      w.r = make_req(CMD_LOOKUP, 2'd0, 32'h1234_5678, 16'h0);  rows.push_back(w);
      w.e.status = ST_BADSEL;
      w.r = make_req(CMD_LOOKUP, 2'd3, 32'hFFFF_FFFF, 16'h0);  rows.push_back(w);
      w.r = make_req(CMD_INSERT, 2'd3, 32'h0, 16'hFFFF);       rows.push_back(w);
      w.e = z;
      w.r = make_req(CMD_NONE, 2'd1, 32'hFFFF_FFFF, 16'hFFFF); rows.push_back(w);
      w.r = make_req(CMD_INSERT, 2'd0, 32'hFFFF_FFFF, 16'hFFFF); rows.push_back(w);
      w.known = 0;
      w.r = make_req(CMD_INSERT, 2'd0, 32'h0000_0000, 16'h0001); rows.push_back(w);
      w.r = make_req(CMD_INSERT, 2'd0, 32'h8000_0000, 16'h8000); rows.push_back(w);
      w.r = make_req(CMD_INSERT, 2'd0, 32'h7FFF_FFFF, 16'h7FFF); rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd0, 32'h8000_0000, 16'h0);    rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd0, 32'hFFFF_FFFF, 16'h0);    rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd0, 32'h0000_0000, 16'h0);    rows.push_back(w);
      w.r = make_req(CMD_INSERT, 2'd0, 32'h8000_0000, 16'h5A5A); rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd0, 32'h8000_0000, 16'h0);    rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd0, 32'h8000_0001, 16'h0);    rows.push_back(w);
      w.r = make_req(CMD_INSERT, 2'd1, 32'h0000_FFFF, 16'hA5A5); rows.push_back(w);
      w.r = make_req(CMD_INSERT, 2'd2, 32'hFFFF_0000, 16'h0F0F); rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd1, 32'hFFFF_0000, 16'h0);    rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd2, 32'hFFFF_0000, 16'h0);    rows.push_back(w);
      w.known = 1; w.e = z;
      w.r = make_req(CMD_CLEAR, 2'd3, 32'hFFFF_FFFF, 16'hFFFF);  rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd0, 32'hFFFF_FFFF, 16'h0);    rows.push_back(w);
      w.r = make_req(CMD_LOOKUP, 2'd2, 32'hFFFF_0000, 16'h0);    rows.push_back(w);
      foreach (rows[i]) send_request(rows[i].r, rows[i].known, rows[i].e);

      send_random(140, 1'b1);

      // Hold off until every response is back
      req.valid <= 1'b0;
      wait (expected_rsp_q.size() == 0);
      repeat (20) @(posedge clock);

      // Fill table 0 past capacity to reach the full status
      send_idle_pct = 79;
      recv_idle_pct = 7;
      send_request(make_req(CMD_CLEAR, 2'd0, 32'h0, 16'h0), 1'b0, '0);
      for (int i = 0; i < ENTRIES + 6; i++)
         send_request(make_req(CMD_INSERT, 2'd0, $urandom, 16'($urandom)), 1'b0, '0);
      send_random(40, 1'b0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(190, 1'b1);

      req.valid <= 1'b0;
      wait (expected_rsp_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
